### rtl/cau_pkg.sv
// Package: operation codes, pipeline payload types and saturation helper.
package cau_pkg;

  localparam int FRAC_BITS = 12;

  // Remainder width for the restoring divider; holds (|n| << FRAC_BITS) + d/2 and d << 16.
  localparam int DIV_W = (35 + FRAC_BITS > 49) ? 35 + FRAC_BITS : 49;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  // Front output: operands plus all partial products.
  typedef struct packed {
    logic [1:0]          kind;
    logic signed [15:0]  a_re;
    logic signed [15:0]  a_im;
    logic signed [15:0]  b_re;
    logic signed [15:0]  b_im;
    logic signed [31:0]  p_rr;  // a_re * b_re
    logic signed [31:0]  p_ii;  // a_im * b_im
    logic signed [31:0]  p_ri;  // a_re * b_im
    logic signed [31:0]  p_ir;  // a_im * b_re
    logic signed [31:0]  p_bb;  // b_re * b_re
    logic signed [31:0]  p_cc;  // b_im * b_im
  } cau_op_t;

  // Saturate to 16 bits; bit 16 of the result is the overflow flag.
  function automatic logic [16:0] sat16(input logic signed [33:0] v);
    logic [16:0] r;
    if (v > 34'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -34'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

endpackage

### rtl/cau_if.sv
// Stream interfaces for operand requests and results.
interface cau_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;
  modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] res_re;
  logic signed [15:0] res_im;
  logic               overflow;
  logic               div_zero;
  modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
  modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

### rtl/cau_front.sv
// Front stage: accepts requests and forms all partial products.
module cau_front (
  input  logic              clk,
  input  logic              rst,
  cau_req_if.sink           req,
  output logic              op_valid,
  input  logic              op_ready,
  output cau_pkg::cau_op_t  op
);
  import cau_pkg::*;

  logic adv;

  assign adv       = !op_valid || op_ready;
  assign req.ready = adv;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (adv) begin
      op_valid <= req.valid;
    end
  end

  // Operand and product register
  always_ff @(posedge clk) begin
    if (adv && req.valid) begin
      op.kind <= req.kind;
      op.a_re <= req.a_re;
      op.a_im <= req.a_im;
      op.b_re <= req.b_re;
      op.b_im <= req.b_im;
      op.p_rr <= req.a_re * req.b_re;
      op.p_ii <= req.a_im * req.b_im;
      op.p_ri <= req.a_re * req.b_im;
      op.p_ir <= req.a_im * req.b_re;
      op.p_bb <= req.b_re * req.b_re;
      op.p_cc <= req.b_im * req.b_im;
    end
  end
endmodule

### rtl/cau_fifo.sv
// Two-entry queue between front and back.
module cau_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  cau_pkg::cau_op_t  wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output cau_pkg::cau_op_t  rd_data
);
  import cau_pkg::*;

  cau_op_t    mem [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end
endmodule

### rtl/cau_back.sv
// Back pipeline: sums, rounding, saturation and a 16-stage restoring divider.
module cau_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  input  cau_pkg::cau_op_t  op,
  cau_rsp_if.source         rsp
);
  import cau_pkg::*;

  localparam int NSTG = 16;
  localparam logic signed [33:0] HALF = 34'sd1 <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [33:0] s_re;
    logic signed [33:0] s_im;
    logic [32:0]        d;
  } cau_sum_t;

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic [15:0]       f_re;
    logic [15:0]       f_im;
    logic              f_ovf;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [DIV_W-1:0]  d;
    logic [DIV_W-1:0]  r_re;
    logic [DIV_W-1:0]  r_im;
    logic [15:0]       q_re;
    logic [15:0]       q_im;
  } cau_div_t;

  logic              en;
  logic              a_vld;
  cau_sum_t          a_reg;
  cau_sum_t          a_next;
  logic [NSTG:0]     s_vld;
  cau_div_t          stg [NSTG+1];
  cau_div_t          b_next;

  // Whole pipeline moves unless the output register is held
  assign en       = !rsp.valid || rsp.ready;
  assign op_ready = en;

  // Stage A: exact sums per operation
  always_comb begin
    a_next.kind = op.kind;
    a_next.d    = {1'b0, op.p_bb} + {1'b0, op.p_cc};
    unique case (op.kind)
      KIND_ADD: begin
        a_next.s_re = 34'(op.a_re) + 34'(op.b_re);
        a_next.s_im = 34'(op.a_im) + 34'(op.b_im);
      end
      KIND_SUB: begin
        a_next.s_re = 34'(op.a_re) - 34'(op.b_re);
        a_next.s_im = 34'(op.a_im) - 34'(op.b_im);
      end
      KIND_MUL: begin
        a_next.s_re = 34'(op.p_rr) - 34'(op.p_ii);
        a_next.s_im = 34'(op.p_ri) + 34'(op.p_ir);
      end
      default: begin
        a_next.s_re = 34'(op.p_rr) + 34'(op.p_ii);
        a_next.s_im = 34'(op.p_ir) - 34'(op.p_ri);
      end
    endcase
  end

  // Stage B: rounding and saturation, divider setup
  always_comb begin
    logic signed [33:0] t_re;
    logic signed [33:0] t_im;
    logic [33:0]        m_re;
    logic [33:0]        m_im;
    logic [16:0]        sr;
    logic [16:0]        si;
    logic [DIV_W-1:0]   dh;
    logic [DIV_W-1:0]   dw;
    if (a_reg.kind == KIND_MUL) begin
      t_re = (a_reg.s_re + HALF) >>> FRAC_BITS;
      t_im = (a_reg.s_im + HALF) >>> FRAC_BITS;
    end else begin
      t_re = a_reg.s_re;
      t_im = a_reg.s_im;
    end
    sr = sat16(t_re);
    si = sat16(t_im);
    m_re = a_reg.s_re[33] ? 34'(-a_reg.s_re) : 34'(a_reg.s_re);
    m_im = a_reg.s_im[33] ? 34'(-a_reg.s_im) : 34'(a_reg.s_im);
    dw = {{(DIV_W-33){1'b0}}, a_reg.d};
    dh = dw >> 1;
    b_next.is_div = (a_reg.kind == KIND_DIV);
    b_next.dz     = (a_reg.d == 33'd0);
    b_next.f_re   = sr[15:0];
    b_next.f_im   = si[15:0];
    b_next.f_ovf  = sr[16] || si[16];
    b_next.neg_re = a_reg.s_re[33];
    b_next.neg_im = a_reg.s_im[33];
    b_next.d      = dw;
    b_next.r_re   = ({{(DIV_W-34){1'b0}}, m_re} << FRAC_BITS) + dh;
    b_next.r_im   = ({{(DIV_W-34){1'b0}}, m_im} << FRAC_BITS) + dh;
    b_next.big_re = b_next.r_re >= (dw << 16);
    b_next.big_im = b_next.r_im >= (dw << 16);
    b_next.q_re   = 16'd0;
    b_next.q_im   = 16'd0;
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      s_vld <= '0;
    end else if (en) begin
      a_vld <= op_valid;
      s_vld <= {s_vld[NSTG-1:0], a_vld};
    end
  end

  // Stage A and B registers
  always_ff @(posedge clk) begin
    if (en) begin
      a_reg  <= a_next;
      stg[0] <= b_next;
    end
  end

  // Divider stages, one quotient bit each, most significant first
  for (genvar j = 0; j < NSTG; j++) begin : g_div
    localparam int SH = NSTG - 1 - j;
    cau_div_t         nx;
    logic [DIV_W-1:0] ds;
    always_comb begin
      nx = stg[j];
      ds = stg[j].d << SH;
      if (stg[j].r_re >= ds) begin
        nx.r_re     = stg[j].r_re - ds;
        nx.q_re[SH] = 1'b1;
      end
      if (stg[j].r_im >= ds) begin
        nx.r_im     = stg[j].r_im - ds;
        nx.q_im[SH] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) stg[j+1] <= nx;
    end
  end

  // Signed quotient with saturation; bit 16 is the overflow flag
  function automatic logic [16:0] div_part(input logic big, input logic neg,
                                           input logic [15:0] q);
    logic [16:0] r;
    if (big) begin
      r = neg ? {1'b1, 16'h8000} : {1'b1, 16'h7fff};
    end else if (!neg) begin
      r = (q > 16'd32767) ? {1'b1, 16'h7fff} : {1'b0, q};
    end else begin
      r = (q > 16'd32768) ? {1'b1, 16'h8000} : {1'b0, 16'(~q + 16'd1)};
    end
    return r;
  endfunction

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= s_vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    logic [16:0] dr;
    logic [16:0] di;
    dr = div_part(stg[NSTG].big_re, stg[NSTG].neg_re, stg[NSTG].q_re);
    di = div_part(stg[NSTG].big_im, stg[NSTG].neg_im, stg[NSTG].q_im);
    if (en) begin
      if (!stg[NSTG].is_div) begin
        rsp.res_re   <= stg[NSTG].f_re;
        rsp.res_im   <= stg[NSTG].f_im;
        rsp.overflow <= stg[NSTG].f_ovf;
        rsp.div_zero <= 1'b0;
      end else if (stg[NSTG].dz) begin
        rsp.res_re   <= 16'sd0;
        rsp.res_im   <= 16'sd0;
        rsp.overflow <= 1'b0;
        rsp.div_zero <= 1'b1;
      end else begin
        rsp.res_re   <= dr[15:0];
        rsp.res_im   <= di[15:0];
        rsp.overflow <= dr[16] || di[16];
        rsp.div_zero <= 1'b0;
      end
    end
  end
endmodule

### rtl/complex_arithmetic_unit.sv
// Top level: complex add, subtract, multiply and divide in signed Q4.12.
//
//   channel  dir  contents
//   req      in   kind, a_re, a_im, b_re, b_im
//   rsp      out  res_re, res_im, overflow, div_zero
//
// One transfer per cycle in each direction when neither side stalls.
// Results pass through the product register, queue, two sum stages, 16 divider
// stages (one quotient bit each) and the output register.
// Reset (rst, synchronous) clears all valid flags and the queue.
// An output stall freezes the back pipeline; the front keeps filling the
// two-entry queue and then drops req.ready.
module complex_arithmetic_unit (
  input  logic      clk,
  input  logic      rst,
  cau_req_if.sink   req,
  cau_rsp_if.source rsp
);
  import cau_pkg::*;

  logic    f_valid;
  logic    f_ready;
  cau_op_t f_op;
  logic    q_valid;
  logic    q_ready;
  cau_op_t q_op;

  cau_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (f_valid),
    .op_ready (f_ready),
    .op       (f_op)
  );

  cau_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_op),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_op)
  );

  cau_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (q_valid),
    .op_ready (q_ready),
    .op       (q_op),
    .rsp      (rsp)
  );
endmodule

### tb/complex_arithmetic_unit_tb.sv
// Testbench for the complex arithmetic unit: directed and random operand streams.
module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               ovf;
    logic               dz;
  } cplx_res_t;

  logic clk;
  logic rst;
  cau_req_if req ();
  cau_rsp_if rsp ();

  complex_arithmetic_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  cplx_res_t expected_q[$];
  int        mismatches;
  bit        failed;
  int        idle_pct;
  int        stall_cycles;

  localparam int WATCHDOG_LIMIT = 2000;

  // Clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Saturate a wide value to 16 bits, flagging overflow
  function automatic logic signed [15:0] clamp16(input longint v, inout logic ovf);
    if (v > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      ovf = 1'b1;
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  // Round half up after dropping the fraction bits (arithmetic shift is floor)
  function automatic longint prod_round(input longint x);
    return (x + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  // Rounded quotient n * 2^FRAC_BITS / d, half away from zero, d > 0
  function automatic longint quot_round(input longint n, input longint d);
    longint m;
    longint q;
    m = (n < 0) ? -n : n;
    q = ((m << FRAC_BITS) + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  // Expected result of one complex operation
  function automatic cplx_res_t complex_op(input logic [1:0] kind,
      input logic signed [15:0] ar, input logic signed [15:0] ai,
      input logic signed [15:0] br, input logic signed [15:0] bi);
    cplx_res_t r;
    longint    re;
    longint    im;
    longint    d;
    logic      ovf;
    logic      dz;
    re = 0;
    im = 0;
    ovf = 1'b0;
    dz = 1'b0;
    case (kind)
      KIND_ADD: begin
        re = longint'(ar) + br;
        im = longint'(ai) + bi;
      end
      KIND_SUB: begin
        re = longint'(ar) - br;
        im = longint'(ai) - bi;
      end
      KIND_MUL: begin
        re = prod_round(longint'(ar) * br - longint'(ai) * bi);
        im = prod_round(longint'(ar) * bi + longint'(ai) * br);
      end
      default: begin
        d = longint'(br) * br + longint'(bi) * bi;
        if (d == 0) begin
          dz = 1'b1;
        end else begin
          re = quot_round(longint'(ar) * br + longint'(ai) * bi, d);
          im = quot_round(longint'(ai) * br - longint'(ar) * bi, d);
        end
      end
    endcase
    r.re = clamp16(re, ovf);
    r.im = clamp16(im, ovf);
    r.ovf = ovf;
    r.dz = dz;
    return r;
  endfunction

  // Send one request; random gaps before valid
  task automatic send_op(input logic [1:0] kind, input logic signed [15:0] ar,
      input logic signed [15:0] ai, input logic signed [15:0] br,
      input logic signed [15:0] bi);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.kind  <= kind;
    req.a_re  <= ar;
    req.a_im  <= ai;
    req.b_re  <= br;
    req.b_im  <= bi;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_q.push_back(complex_op(kind, ar, ai, br, bi));
  endtask

  task automatic drop_valid();
    req.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] edge_val();
    case ($urandom_range(5))
      0: return -16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'sh1000;
      4: return -16'sh1000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Response ready and checking
  always @(posedge clk) begin
    cplx_res_t e;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected result re=%0d im=%0d",
                                         rsp.res_re, rsp.res_im);
        end else begin
          e = expected_q.pop_front();
          if (rsp.res_re !== e.re || rsp.res_im !== e.im ||
              rsp.overflow !== e.ovf || rsp.div_zero !== e.dz) begin
            failed = 1'b1;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp re=%0d im=%0d ovf=%b dz=%b got re=%0d im=%0d ovf=%b dz=%b",
                       e.re, e.im, e.ovf, e.dz,
                       rsp.res_re, rsp.res_im, rsp.overflow, rsp.div_zero);
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Operand extremes for every operation, plus zero divisor and overflow
  task automatic test_directed();
    for (int k = 0; k < 4; k++) begin
      send_op(2'(k), 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_op(2'(k), -16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000);
      send_op(2'(k), 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh7fff);
      send_op(2'(k), 16'sh1800, -16'sh0800, 16'sh0000, 16'sh0000);
      send_op(2'(k), 16'sh1000, 16'sh0000, 16'sh1000, 16'sh0000);
    end
    send_op(KIND_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_op(KIND_DIV, 16'sh7fff, 16'sh0000, 16'sh0001, 16'sh0000);
    send_op(KIND_MUL, 16'sh0001, 16'sh0000, 16'sh0800, 16'sh0000);
    send_op(KIND_MUL, -16'sh0001, 16'sh0000, 16'sh0800, 16'sh0000);
    wait_drained();
  endtask

  // Random operands, with boundary values mixed in for about a quarter of requests
  task automatic test_random(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        send_op(2'($urandom), edge_val(), edge_val(), edge_val(), edge_val());
      else
        send_op(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom));
    end
  endtask

  // Small-magnitude operands keep add, subtract and multiply results in range
  task automatic test_small(input int count);
    for (int i = 0; i < count; i++)
      send_op(2'($urandom), 16'($urandom_range(8192) - 4096),
              16'($urandom_range(8192) - 4096),
              16'($urandom_range(8192) - 4096),
              16'($urandom_range(8192) - 4096));
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.kind = KIND_ADD;
    req.a_re = '0;
    req.a_im = '0;
    req.b_re = '0;
    req.b_im = '0;
    rsp.ready = 1'b0;
    mismatches = 0;
    failed = 1'b0;
    idle_pct = 12;
    stall_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(300, 12);
    test_random(200, 0);
    wait_drained();
    idle_pct = 12;
    test_small(280);

    wait_drained();
    repeat (40) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
